// ----- rtl/vtsr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vtsr_pkg: shared types and constants of the vertex transform core
// Register indexes, transform modes, reset values and the saturate and
// divide-step helpers used by the datapath.
// ----------------------------------------------------------------------------
package vtsr_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned IdxW      = 3;
  // quotient of the reflect term stays below 2^33, one extra bit of margin
  localparam int unsigned QBits     = 34;
  localparam int unsigned NumW      = 96;
  localparam int unsigned RemW      = 64;

  typedef enum logic [1:0] {
    MODE_TRANSLATE = 2'd0,
    MODE_SCALE     = 2'd1,
    MODE_REFLECT   = 2'd2,
    MODE_NONE      = 2'd3
  } mode_e;

  typedef enum logic [IdxW-1:0] {
    REG_MODE     = 3'd0,
    REG_OFFSET_X = 3'd1,
    REG_OFFSET_Y = 3'd2,
    REG_FACTOR_X = 3'd3,
    REG_FACTOR_Y = 3'd4,
    REG_AXIS_X   = 3'd5,
    REG_AXIS_Y   = 3'd6,
    REG_UNUSED   = 3'd7
  } reg_idx_e;

  localparam logic signed [CoordW-1:0] OffsetReset = 32'sd0;
  localparam logic signed [CoordW-1:0] FactorReset = 32'sd65536;
  localparam logic signed [CoordW-1:0] AxisXReset  = 32'sd65536;
  localparam logic signed [CoordW-1:0] AxisYReset  = 32'sd0;

  typedef struct packed {
    logic signed [CoordW-1:0] val;
    logic                     ovf;
  } sat_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [QBits-1:0] w;
  } div_t;

  // per-beat payload carried alongside the divider
  typedef struct packed {
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] ex;
    logic signed [CoordW-1:0] ey;
    logic                     ovf;
    logic                     bad;
    logic                     refl;
    logic                     negx;
    logic                     negy;
  } com_t;

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t s;
    if (v > 66'sd2147483647) begin
      s.val = 32'sh7fffffff;
      s.ovf = 1'b1;
    end else if (v < -66'sd2147483648) begin
      s.val = 32'sh80000000;
      s.ovf = 1'b1;
    end else begin
      s.val = v[CoordW-1:0];
      s.ovf = 1'b0;
    end
    return s;
  endfunction

  // one restoring division step: next numerator bit leaves w, quotient bit enters
  function automatic div_t div_step(input div_t cur, input logic [RemW-1:0] n);
    div_t nx;
    logic [RemW-1:0] t;
    logic            qb;
    t  = {cur.rem[RemW-2:0], cur.w[QBits-1]};
    qb = (t >= n);
    nx.rem = qb ? t - n : t;
    nx.w   = {cur.w[QBits-2:0], qb};
    return nx;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/vertex_translate_scale_reflect_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_translate_scale_reflect_core: 2d vertex translate, scale or reflect
// One vertex in, one saturated vertex out per beat. The block accepts a new
// beat every cycle while the output is not stalled. Each beat passes through
// one multiply stage, one sum stage, two stages for the wide reflect product,
// 34 stages of the pipelined restoring divider (one quotient bit per stage)
// and the output register. The divider depth sets the latency in every mode.
// When the output is stalled the whole pipeline holds. The user must write
// configuration only while the pipeline is empty; the block does not enforce it.
// ----------------------------------------------------------------------------
module vertex_translate_scale_reflect_core #(
  parameter int unsigned FRAC_BITS = vtsr_pkg::FracBits
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [vtsr_pkg::IdxW-1:0]      cfg_index_i,
  input  wire logic [vtsr_pkg::CoordW-1:0]    cfg_wdata_i,
  input  wire logic                           valid_i,
  output logic                                stall_o,
  input  wire logic signed [vtsr_pkg::CoordW-1:0] point_x_i,
  input  wire logic signed [vtsr_pkg::CoordW-1:0] point_y_i,
  output logic                                valid_o,
  input  wire logic                           stall_i,
  output logic signed [vtsr_pkg::CoordW-1:0]  result_x_o,
  output logic signed [vtsr_pkg::CoordW-1:0]  result_y_o,
  output logic                                overflow_o,
  output logic                                bad_axis_o
);

  localparam int unsigned QB = vtsr_pkg::QBits;
  localparam int unsigned NW = vtsr_pkg::NumW;
  localparam int unsigned RW = vtsr_pkg::RemW;
  localparam logic signed [63:0] RndMask = (64'sd1 <<< FRAC_BITS) - 64'sd1;

  // configuration
  vtsr_pkg::mode_e          mode_q;
  logic signed [31:0]       off_x_q, off_y_q, fac_x_q, fac_y_q, ax_q, ay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= vtsr_pkg::MODE_TRANSLATE;
      off_x_q <= vtsr_pkg::OffsetReset;
      off_y_q <= vtsr_pkg::OffsetReset;
      fac_x_q <= vtsr_pkg::FactorReset;
      fac_y_q <= vtsr_pkg::FactorReset;
      ax_q    <= vtsr_pkg::AxisXReset;
      ay_q    <= vtsr_pkg::AxisYReset;
    end else if (cfg_we_i) begin
      unique case (vtsr_pkg::reg_idx_e'(cfg_index_i))
        vtsr_pkg::REG_MODE:     mode_q  <= vtsr_pkg::mode_e'(cfg_wdata_i[1:0]);
        vtsr_pkg::REG_OFFSET_X: off_x_q <= cfg_wdata_i;
        vtsr_pkg::REG_OFFSET_Y: off_y_q <= cfg_wdata_i;
        vtsr_pkg::REG_FACTOR_X: fac_x_q <= cfg_wdata_i;
        vtsr_pkg::REG_FACTOR_Y: fac_y_q <= cfg_wdata_i;
        vtsr_pkg::REG_AXIS_X:   ax_q    <= cfg_wdata_i;
        vtsr_pkg::REG_AXIS_Y:   ay_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_v_q;
  assign stall_o = out_v_q && stall_i;
  assign en      = !stall_o;

  // stage 1: products and translate sums
  logic               v1_q;
  logic signed [31:0] px1_q, py1_q;
  logic signed [32:0] sx1_q, sy1_q;
  logic signed [63:0] fx1_q, fy1_q, dx1_q, dy1_q, nx1_q, ny1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px1_q <= point_x_i;
      py1_q <= point_y_i;
      sx1_q <= 33'(point_x_i) + 33'(off_x_q);
      sy1_q <= 33'(point_y_i) + 33'(off_y_q);
      fx1_q <= 64'(point_x_i) * 64'(fac_x_q);
      fy1_q <= 64'(point_y_i) * 64'(fac_y_q);
      dx1_q <= 64'(point_x_i) * 64'(ax_q);
      dy1_q <= 64'(point_y_i) * 64'(ay_q);
      nx1_q <= 64'(ax_q) * 64'(ax_q);
      ny1_q <= 64'(ay_q) * 64'(ay_q);
    end
  end

  // stage 2: dot product, norm, early results
  logic signed [64:0] dot_d;
  logic [63:0]        norm_d, dmag_d, fx_adj, fy_adj;
  logic signed [63:0] fxs_d, fys_d;
  vtsr_pkg::sat_t     satx_d, saty_d;
  vtsr_pkg::com_t     com2_d;
  logic               dneg_d;

  always_comb begin
    dot_d  = 65'(dx1_q) + 65'(dy1_q);
    norm_d = nx1_q + ny1_q;
    dneg_d = dot_d[64];
    dmag_d = dneg_d ? 64'(-dot_d) : dot_d[63:0];
    fx_adj = fx1_q + (fx1_q[63] ? RndMask : 64'sd0);
    fy_adj = fy1_q + (fy1_q[63] ? RndMask : 64'sd0);
    fxs_d  = $signed(fx_adj) >>> FRAC_BITS;
    fys_d  = $signed(fy_adj) >>> FRAC_BITS;
    com2_d = '0;
    com2_d.px = px1_q;
    com2_d.py = py1_q;
    com2_d.ex = px1_q;
    com2_d.ey = py1_q;
    satx_d = vtsr_pkg::sat32(66'(sx1_q));
    saty_d = vtsr_pkg::sat32(66'(sy1_q));
    case (mode_q)
      vtsr_pkg::MODE_TRANSLATE: begin
        com2_d.ex  = satx_d.val;
        com2_d.ey  = saty_d.val;
        com2_d.ovf = satx_d.ovf | saty_d.ovf;
      end
      vtsr_pkg::MODE_SCALE: begin
        satx_d = vtsr_pkg::sat32(66'(fxs_d));
        saty_d = vtsr_pkg::sat32(66'(fys_d));
        com2_d.ex  = satx_d.val;
        com2_d.ey  = saty_d.val;
        com2_d.ovf = satx_d.ovf | saty_d.ovf;
      end
      vtsr_pkg::MODE_REFLECT: begin
        com2_d.bad  = (norm_d == '0);
        com2_d.refl = (norm_d != '0);
      end
      default: ;
    endcase
    com2_d.negx = ax_q[31] ^ dneg_d;
    com2_d.negy = ay_q[31] ^ dneg_d;
  end

  logic           v2_q;
  vtsr_pkg::com_t com2_q;
  logic [63:0]    norm2_q, dmag2_q;
  logic [31:0]    amx2_q, amy2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      com2_q  <= com2_d;
      norm2_q <= norm_d;
      dmag2_q <= dmag_d;
      amx2_q  <= ax_q[31] ? 32'(-ax_q) : ax_q;
      amy2_q  <= ay_q[31] ? 32'(-ay_q) : ay_q;
    end
  end

  // stage 3: partial products of |axis| * |dot|
  logic           v3_q;
  vtsr_pkg::com_t com3_q;
  logic [63:0]    norm3_q, plx3_q, phx3_q, ply3_q, phy3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      com3_q  <= com2_q;
      norm3_q <= norm2_q;
      plx3_q  <= 64'(amx2_q) * 64'(dmag2_q[31:0]);
      phx3_q  <= 64'(amx2_q) * 64'(dmag2_q[63:32]);
      ply3_q  <= 64'(amy2_q) * 64'(dmag2_q[31:0]);
      phy3_q  <= 64'(amy2_q) * 64'(dmag2_q[63:32]);
    end
  end

  // stage 4: numerator 2*|a|*|dot|, loaded into divider stage zero
  logic [NW-1:0] numx_d, numy_d;
  assign numx_d = NW'(({phx3_q, 32'd0} + NW'(plx3_q)) << 1);
  assign numy_d = NW'(({phy3_q, 32'd0} + NW'(ply3_q)) << 1);

  logic           dv_q   [QB+1];
  vtsr_pkg::com_t dcom_q [QB+1];
  vtsr_pkg::div_t ddx_q  [QB+1];
  vtsr_pkg::div_t ddy_q  [QB+1];
  logic [RW-1:0]  dn_q   [QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dcom_q[0]    <= com3_q;
      dn_q[0]      <= norm3_q;
      ddx_q[0].rem <= RW'(numx_d[NW-1:QB]);
      ddx_q[0].w   <= numx_d[QB-1:0];
      ddy_q[0].rem <= RW'(numy_d[NW-1:QB]);
      ddy_q[0].w   <= numy_d[QB-1:0];
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_q[k+1] <= dv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dcom_q[k+1] <= dcom_q[k];
        dn_q[k+1]   <= dn_q[k];
        ddx_q[k+1]  <= vtsr_pkg::div_step(ddx_q[k], dn_q[k]);
        ddy_q[k+1]  <= vtsr_pkg::div_step(ddy_q[k], dn_q[k]);
      end
    end
  end

  // final: sign, subtract the vertex, saturate
  vtsr_pkg::com_t     fc;
  logic signed [QB:0] tx_d, ty_d;
  logic signed [QB+1:0] rx_d, ry_d;
  vtsr_pkg::sat_t     fx_d, fy_d;
  logic signed [31:0] resx_d, resy_d;
  logic               ovf_d;

  always_comb begin
    fc     = dcom_q[QB];
    tx_d   = fc.negx ? -$signed({1'b0, ddx_q[QB].w}) : $signed({1'b0, ddx_q[QB].w});
    ty_d   = fc.negy ? -$signed({1'b0, ddy_q[QB].w}) : $signed({1'b0, ddy_q[QB].w});
    rx_d   = (QB+2)'(tx_d) - (QB+2)'(fc.px);
    ry_d   = (QB+2)'(ty_d) - (QB+2)'(fc.py);
    fx_d   = vtsr_pkg::sat32(66'(rx_d));
    fy_d   = vtsr_pkg::sat32(66'(ry_d));
    resx_d = fc.refl ? fx_d.val : fc.ex;
    resy_d = fc.refl ? fy_d.val : fc.ey;
    ovf_d  = fc.refl ? (fx_d.ovf | fy_d.ovf) : fc.ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      result_x_o <= resx_d;
      result_y_o <= resy_d;
      overflow_o <= ovf_d;
      bad_axis_o <= fc.bad;
    end
  end

  assign valid_o = out_v_q;

  // a zero axis passes the vertex through, so it never saturates
  a_bad_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !(overflow_o && bad_axis_o))
    else $error("bad_axis and overflow both set");

  a_bad_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && bad_axis_o |-> mode_q == vtsr_pkg::MODE_REFLECT)
    else $error("bad_axis outside reflect mode");

  a_div_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[QB] && en |=> out_v_q)
    else $error("divider beat lost before output");

endmodule
`default_nettype wire
